/* rtl/mcg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcg_pkg
// Shared widths, constants and control types of the midpoint circle generator.
// ----------------------------------------------------------------------------
package mcg_pkg;

    localparam int CELL_W   = 12;   // cell corner and size fields
    localparam int PAD_W    = 10;   // padding register
    localparam int SUM_W    = 14;   // signed width + height - 2*padding
    localparam int CTR_W    = 13;   // center coordinate
    localparam int RAD_W    = 7;    // radius and offsets
    localparam int DEC_W    = 10;   // signed decision variable
    localparam int GMIN_W   = 8;    // minor gradient, unsigned
    localparam int GMAJ_W   = 9;    // major gradient, signed
    localparam int COORD_W  = 14;   // signed output coordinate
    localparam int CNT_W    = 6;    // result count within one circle

    localparam int MAX_RADIUS_DEF = 88;
    localparam logic [PAD_W-1:0] PAD_RESET = PAD_W'(30);
    localparam logic [CNT_W-1:0] CNT_LAST  = {CNT_W{1'b1}};   // 64th result

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RUN
    } state_t;

    typedef struct packed {
        logic load;     // take a request into the recurrence state
        logic emit;     // load the output register and advance one step
    } cmd_t;

    typedef struct packed {
        logic last;     // current step is the final one of the circle
    } sts_t;

endpackage

/* rtl/mcg_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcg_ctrl
// Request sequencer: accepts a circle request, then paces one point set per
// free output slot until the final one is issued.
// ----------------------------------------------------------------------------
module mcg_ctrl
    import mcg_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    output logic out_valid,
    input  logic out_stall,
    output cmd_t cmd,
    input  sts_t sts
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.emit   = 1'b0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                // slot is free when empty or being taken this cycle
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.emit = 1'b1;
                    if (sts.last)
                        state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase

        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

`ifndef ASSERT_OFF
    a_load_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == ST_RUN))
        else $error("request accepted but sequencer not running");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && sts.last) |=> (state_reg == ST_IDLE))
        else $error("final point set issued but sequencer still running");

    a_emit_fills_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid_reg)
        else $error("point set issued but output slot empty");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !cmd.emit)
        else $error("stalled point set overwritten");
`endif

endmodule

/* rtl/mcg_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcg_datapath
// Radius and center setup, midpoint recurrence state and output register.
// ----------------------------------------------------------------------------
module mcg_datapath
    import mcg_pkg::*;
#(
    parameter int MAX_RADIUS = MAX_RADIUS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wen,
    input  logic [PAD_W-1:0]          cfg_wdata,
    input  logic [CELL_W-1:0]         cell_left,
    input  logic [CELL_W-1:0]         cell_top,
    input  logic [CELL_W-1:0]         cell_width,
    input  logic [CELL_W-1:0]         cell_height,
    input  cmd_t                      cmd,
    output sts_t                      sts,
    output logic signed [COORD_W-1:0] x_plus_minor,
    output logic signed [COORD_W-1:0] x_minus_minor,
    output logic signed [COORD_W-1:0] x_plus_major,
    output logic signed [COORD_W-1:0] x_minus_major,
    output logic signed [COORD_W-1:0] y_plus_major,
    output logic signed [COORD_W-1:0] y_minus_major,
    output logic signed [COORD_W-1:0] y_plus_minor,
    output logic signed [COORD_W-1:0] y_minus_minor,
    output logic                      axis_step,
    output logic                      last_point_set
);

    localparam logic [RAD_W-1:0] RAD_MAX = RAD_W'(MAX_RADIUS);

    logic [PAD_W-1:0]  pad_reg;
    logic [CTR_W-1:0]  cx_reg, cy_reg;
    logic [RAD_W-1:0]  minor_reg, major_reg;
    logic [DEC_W-1:0]  dec_reg;
    logic [GMIN_W-1:0] gmin_reg;
    logic [GMAJ_W-1:0] gmaj_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              first_reg;

    // setup terms
    logic [SUM_W-1:0]  sum;
    logic [SUM_W-3:0]  rad_raw;
    logic [RAD_W-1:0]  radius;

    // step terms
    logic              dec_ge0;
    logic [GMAJ_W-1:0] gmaj_step;
    logic [GMIN_W-1:0] gmin_step;
    logic [DEC_W-1:0]  dec_mid;
    logic [DEC_W-1:0]  dec_step;

    logic [COORD_W-1:0] cx14, cy14, m14, mj14;

    always_comb
    begin
        sum = {2'b00, cell_width} + {2'b00, cell_height}
            - {{(SUM_W-PAD_W-1){1'b0}}, pad_reg, 1'b0};
        // negative or zero sum gives radius 0
        if (sum[SUM_W-1] || (sum == '0))
            rad_raw = '0;
        else
            rad_raw = sum[SUM_W-1:2];
        if (rad_raw > {{(SUM_W-2-RAD_W){1'b0}}, RAD_MAX})
            radius = RAD_MAX;
        else
            radius = rad_raw[RAD_W-1:0];
    end

    always_comb
    begin
        dec_ge0   = !dec_reg[DEC_W-1];
        gmaj_step = gmaj_reg + GMAJ_W'(2);
        gmin_step = gmin_reg + GMIN_W'(2);
        dec_mid   = dec_ge0 ? dec_reg + {gmaj_step[GMAJ_W-1], gmaj_step} : dec_reg;
        dec_step  = dec_mid + {{(DEC_W-GMIN_W){1'b0}}, gmin_step} + DEC_W'(1);
        sts.last  = !(minor_reg < major_reg) || (cnt_reg == CNT_LAST);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pad_reg <= PAD_RESET;
        else if (cfg_wen)
            pad_reg <= cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg    <= '0;
            cy_reg    <= '0;
            minor_reg <= '0;
            major_reg <= '0;
            dec_reg   <= '0;
            gmin_reg  <= '0;
            gmaj_reg  <= '0;
            cnt_reg   <= '0;
            first_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            cx_reg    <= {1'b0, cell_left} + {2'b00, cell_width[CELL_W-1:1]};
            cy_reg    <= {1'b0, cell_top} + {2'b00, cell_height[CELL_W-1:1]};
            minor_reg <= '0;
            major_reg <= radius;
            dec_reg   <= DEC_W'(1) - {{(DEC_W-RAD_W){1'b0}}, radius};
            gmin_reg  <= '0;
            gmaj_reg  <= GMAJ_W'(0) - {{(GMAJ_W-RAD_W-1){1'b0}}, radius, 1'b0};
            cnt_reg   <= '0;
            first_reg <= 1'b1;
        end
        else if (cmd.emit)
        begin
            // state is left untouched after the final step
            if (!sts.last)
            begin
                minor_reg <= minor_reg + RAD_W'(1);
                if (dec_ge0)
                begin
                    major_reg <= major_reg - RAD_W'(1);
                    gmaj_reg  <= gmaj_step;
                end
                gmin_reg <= gmin_step;
                dec_reg  <= dec_step;
                cnt_reg  <= cnt_reg + CNT_W'(1);
            end
            first_reg <= 1'b0;
        end
    end

    assign cx14 = {1'b0, cx_reg};
    assign cy14 = {1'b0, cy_reg};
    assign m14  = {{(COORD_W-RAD_W){1'b0}}, minor_reg};
    assign mj14 = {{(COORD_W-RAD_W){1'b0}}, major_reg};

    // output register, payload only
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            x_plus_minor   <= cx14 + m14;
            x_minus_minor  <= cx14 - m14;
            x_plus_major   <= cx14 + mj14;
            x_minus_major  <= cx14 - mj14;
            y_plus_major   <= cy14 + mj14;
            y_minus_major  <= cy14 - mj14;
            y_plus_minor   <= cy14 + m14;
            y_minus_minor  <= cy14 - m14;
            axis_step      <= first_reg;
            last_point_set <= sts.last;
        end
    end

endmodule

/* rtl/midpoint_circle_generator.sv */
`timescale 1ns / 1ps
// The first point set of a request passes the recurrence state loaded at accept, then the output register.
// Throughput: one point set per cycle while the output is not stalled; a circle of
//   N point sets (N = radius steps, at most 64) holds the request side until the final one is issued.
// The next request is taken while the final point set still waits at the output.
// Reset: asynchronous, active low; padding returns to 30, the block is idle, no output.
// ----------------------------------------------------------------------------
// midpoint_circle_generator
// Derives center and radius of a cell and walks the integer midpoint circle
// recurrence over one octant, one eight-point set per result.
// ----------------------------------------------------------------------------
module midpoint_circle_generator
    import mcg_pkg::*;
#(
    parameter int MAX_RADIUS = MAX_RADIUS_DEF   // radius saturation, 1 to 88
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    // padding register write
    input  logic                      cfg_wen,
    input  logic [PAD_W-1:0]          cfg_wdata,
    // circle request
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [CELL_W-1:0]         cell_left,
    input  logic [CELL_W-1:0]         cell_top,
    input  logic [CELL_W-1:0]         cell_width,
    input  logic [CELL_W-1:0]         cell_height,
    // point sets
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [COORD_W-1:0] x_plus_minor,
    output logic signed [COORD_W-1:0] x_minus_minor,
    output logic signed [COORD_W-1:0] x_plus_major,
    output logic signed [COORD_W-1:0] x_minus_major,
    output logic signed [COORD_W-1:0] y_plus_major,
    output logic signed [COORD_W-1:0] y_minus_major,
    output logic signed [COORD_W-1:0] y_plus_minor,
    output logic signed [COORD_W-1:0] y_minus_minor,
    output logic                      axis_step,
    output logic                      last_point_set
);

    // Controller and datapath talk only through these two groups:
    //   cmd.load - request accepted; datapath latches center, radius and
    //              the recurrence start values (decision 1-r, gradient -2r).
    //   cmd.emit - output slot free; datapath registers the current eight
    //              points and advances the recurrence by one step.
    //   sts.last - the current step is the final one (minor reached major,
    //              or the 64-result bound).
    cmd_t cmd;
    sts_t sts;

    mcg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    // The datapath holds the padding register, the recurrence state and
    // the output register. Center and radius are formed in the accept
    // cycle; each step is one add chain on the 10-bit decision variable.
    mcg_datapath #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wen        (cfg_wen),
        .cfg_wdata      (cfg_wdata),
        .cell_left      (cell_left),
        .cell_top       (cell_top),
        .cell_width     (cell_width),
        .cell_height    (cell_height),
        .cmd            (cmd),
        .sts            (sts),
        .x_plus_minor   (x_plus_minor),
        .x_minus_minor  (x_minus_minor),
        .x_plus_major   (x_plus_major),
        .x_minus_major  (x_minus_major),
        .y_plus_major   (y_plus_major),
        .y_minus_major  (y_minus_major),
        .y_plus_minor   (y_plus_minor),
        .y_minus_minor  (y_minus_minor),
        .axis_step      (axis_step),
        .last_point_set (last_point_set)
    );

endmodule
